>>> hw/rtl/pfld_pkg.sv
// Shared constants, codes, types and the span mask function of the line drawer.
package pfld_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
    localparam int FRAME_SIZE    = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(FRAME_SIZE);
    localparam int CNT_W         = $clog2(FRAME_SIZE + 1);
    localparam int COL_W         = $clog2(SCREEN_WIDTH);
    localparam int CRD_W         = 18;

    typedef enum logic [2:0] {
        MODE_PIXEL = 3'd0,
        MODE_HRUN  = 3'd1,
        MODE_VRUN  = 3'd2,
        MODE_CLEAR = 3'd3,
        MODE_READ  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        COLOR_BLACK  = 2'd0,
        COLOR_WHITE  = 2'd1,
        COLOR_INVERT = 2'd2
    } t_color;

    typedef enum logic [2:0] {
        S_WIPE,
        S_IDLE,
        S_CLIP,
        S_PLAN,
        S_RD,
        S_WR,
        S_FETCH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_ram_req;

    function automatic logic [7:0] f_span_mask(input logic [2:0] lo, input logic [3:0] hi);
        logic [7:0] m;
        for (int i = 0; i < 8; i++) begin
            m[i] = (4'(i) >= {1'b0, lo}) && (4'(i) < hi);
        end
        return m;
    endfunction

endpackage

>>> hw/rtl/page_framebuffer_line_drawer_core.sv
// Top level of the page-packed frame buffer pixel and line drawer.
// Each request word is taken only while o_in_stall is low, and exactly one result word follows.
// After reset the block sweeps the whole buffer to zero, one byte per cycle (FRAME_SIZE bytes,
// 1024 at the default size), with o_in_stall high. All buffer traffic goes through one
// single-port memory, so every drawn byte is a read cycle followed by a write cycle. A
// horizontal run writes one byte per covered column, a vertical run one byte per covered
// page (at most 8 pages), and a clear sweeps all FRAME_SIZE bytes. A result waits in the
// output register until it is taken.
module page_framebuffer_line_drawer_core
    import pfld_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_mode,
    input  logic signed [15:0] i_x_pos,
    input  logic signed [15:0] i_y_pos,
    input  logic signed [15:0] i_run_length,
    input  logic [1:0]         i_color,
    input  logic [9:0]         i_byte_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_read_data
);

    localparam logic signed [CRD_W-1:0] WIDTH_S  = CRD_W'(SCREEN_WIDTH);
    localparam logic signed [CRD_W-1:0] HEIGHT_S = CRD_W'(SCREEN_HEIGHT);

    t_state                   r_state;
    t_state                   n_state;
    logic [2:0]               r_mode;
    logic signed [15:0]       r_x;
    logic signed [15:0]       r_y;
    logic signed [15:0]       r_len;
    logic [1:0]               r_color;
    logic [9:0]               r_idx;
    logic signed [CRD_W-1:0]  r_lo;
    logic signed [CRD_W-1:0]  r_hi;
    logic                     r_ok;
    logic                     r_vert;
    logic [ADDR_W-1:0]        r_addr;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_first;
    logic [2:0]               r_lo_bit;
    logic [3:0]               r_hi_bit;
    logic [7:0]               r_hmask;
    logic [7:0]               r_result;
    logic                     r_reply;
    logic                     r_out_valid;
    logic [7:0]               r_out_data;

    t_ram_req                 ram_req;
    logic [7:0]               ram_q;
    logic [7:0]               cur_mask;
    logic [7:0]               new_byte;
    logic                     out_load;
    logic                     last_byte;

    logic                     is_vert;
    logic signed [CRD_W-1:0]  coord;
    logic signed [CRD_W-1:0]  other;
    logic signed [CRD_W-1:0]  span_len;
    logic signed [CRD_W-1:0]  lim;
    logic signed [CRD_W-1:0]  olim;
    logic signed [CRD_W-1:0]  run_end;
    logic signed [CRD_W-1:0]  clip_lo;
    logic signed [CRD_W-1:0]  clip_hi;
    logic                     clip_ok;

    logic signed [CRD_W-1:0]  span;
    logic signed [CRD_W-1:0]  last_row;
    logic                     nonempty;
    logic [CNT_W-1:0]         plan_cnt;
    logic [ADDR_W-1:0]        plan_addr;
    logic                     idx_ok;

    // Clipping of the run span against the screen.
    always_comb begin
        is_vert  = (r_mode == MODE_VRUN);
        coord    = is_vert ? {{2{r_y[15]}}, r_y} : {{2{r_x[15]}}, r_x};
        other    = is_vert ? {{2{r_x[15]}}, r_x} : {{2{r_y[15]}}, r_y};
        span_len = (r_mode == MODE_PIXEL) ? CRD_W'(1) : {{2{r_len[15]}}, r_len};
        lim      = is_vert ? HEIGHT_S : WIDTH_S;
        olim     = is_vert ? WIDTH_S : HEIGHT_S;
        run_end  = coord + span_len;
        clip_lo  = (coord < 0) ? '0 : coord;
        clip_hi  = (run_end > lim) ? lim : run_end;
        clip_ok  = (other >= 0) && (other < olim) && (r_color != 2'd3);
    end

    // Byte count and first address of the clipped run.
    always_comb begin
        span     = r_hi - r_lo;
        last_row = r_hi - CRD_W'(1);
        nonempty = r_ok && (span > 0);
        if (r_vert) begin
            plan_cnt  = CNT_W'(last_row[5:3] - r_lo[5:3]) + CNT_W'(1);
            plan_addr = ADDR_W'(r_lo[5:3] * SCREEN_WIDTH) + ADDR_W'(r_x[COL_W-1:0]);
        end else begin
            plan_cnt  = CNT_W'(span);
            plan_addr = ADDR_W'(r_y[5:3] * SCREEN_WIDTH) + ADDR_W'(r_lo);
        end
        idx_ok    = int'(r_idx) < FRAME_SIZE;
        last_byte = (r_cnt == CNT_W'(1));
    end

    always_comb begin
        if (r_vert) begin
            cur_mask = f_span_mask(r_first ? r_lo_bit : 3'd0, last_byte ? r_hi_bit : 4'd8);
        end else begin
            cur_mask = r_hmask;
        end
    end

    pfld_alu u_alu (
        .i_byte  (ram_q),
        .i_mask  (cur_mask),
        .i_color (r_color),
        .o_byte  (new_byte)
    );

    pfld_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_q)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_WIPE: begin
                if (last_byte) begin
                    n_state = r_reply ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CLIP;
                end
            end
            S_CLIP: begin
                unique case (r_mode) inside
                    MODE_PIXEL, MODE_HRUN, MODE_VRUN: n_state = S_PLAN;
                    MODE_CLEAR:                       n_state = S_WIPE;
                    MODE_READ:                        n_state = S_FETCH;
                    default:                          n_state = S_DONE;
                endcase
            end
            S_PLAN:  n_state = nonempty ? S_RD : S_DONE;
            S_RD:    n_state = S_WR;
            S_WR:    n_state = last_byte ? S_DONE : S_RD;
            S_FETCH: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        ram_req    = '0;
        o_in_stall = 1'b1;
        out_load   = 1'b0;
        unique case (r_state)
            S_WIPE: begin
                ram_req.wr_en = 1'b1;
                ram_req.addr  = r_addr;
            end
            S_IDLE: o_in_stall = 1'b0;
            S_CLIP: begin
                ram_req.rd_en = (r_mode == MODE_READ);
                ram_req.addr  = ADDR_W'(r_idx);
            end
            S_RD: begin
                ram_req.rd_en = 1'b1;
                ram_req.addr  = r_addr;
            end
            S_WR: begin
                ram_req.wr_en = 1'b1;
                ram_req.addr  = r_addr;
                ram_req.wdata = new_byte;
            end
            S_DONE:  out_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WIPE;
            r_addr      <= '0;
            r_cnt       <= CNT_W'(FRAME_SIZE);
            r_reply     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_result;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_WIPE: begin
                    r_addr <= r_addr + ADDR_W'(1);
                    r_cnt  <= r_cnt - CNT_W'(1);
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode  <= i_mode;
                        r_x     <= i_x_pos;
                        r_y     <= i_y_pos;
                        r_len   <= i_run_length;
                        r_color <= i_color;
                        r_idx   <= i_byte_index;
                    end
                end
                S_CLIP: begin
                    r_lo     <= clip_lo;
                    r_hi     <= clip_hi;
                    r_ok     <= clip_ok;
                    r_vert   <= is_vert;
                    r_result <= '0;
                    if (r_mode == MODE_CLEAR) begin
                        r_addr  <= '0;
                        r_cnt   <= CNT_W'(FRAME_SIZE);
                        r_reply <= 1'b1;
                    end
                end
                S_PLAN: begin
                    r_addr   <= plan_addr;
                    r_cnt    <= plan_cnt;
                    r_first  <= 1'b1;
                    r_lo_bit <= r_lo[2:0];
                    r_hi_bit <= {1'b0, last_row[2:0]} + 4'd1;
                    r_hmask  <= 8'd1 << r_y[2:0];
                end
                S_WR: begin
                    r_addr  <= r_addr + (r_vert ? ADDR_W'(SCREEN_WIDTH) : ADDR_W'(1));
                    r_cnt   <= r_cnt - CNT_W'(1);
                    r_first <= 1'b0;
                end
                S_FETCH: r_result <= idx_ok ? ram_q : 8'd0;
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

endmodule

>>> hw/rtl/pfld_ram.sv
// Single-port frame buffer memory with registered read data.
module pfld_ram
    import pfld_pkg::*;
(
    input  logic       i_clk,
    input  t_ram_req   i_req,
    output logic [7:0] o_rdata
);

    logic [7:0] r_mem [FRAME_SIZE];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/pfld_alu.sv
// Shared byte update unit that clears, sets or toggles the masked bits.
module pfld_alu
    import pfld_pkg::*;
(
    input  logic [7:0] i_byte,
    input  logic [7:0] i_mask,
    input  logic [1:0] i_color,
    output logic [7:0] o_byte
);

    always_comb begin
        case (i_color)
            COLOR_BLACK:  o_byte = i_byte & ~i_mask;
            COLOR_WHITE:  o_byte = i_byte | i_mask;
            COLOR_INVERT: o_byte = i_byte ^ i_mask;
            default:      o_byte = i_byte;
        endcase
    end

endmodule

>>> hw/rtl/pfld_checker.sv
// Port-level assertions for the line drawer and the bind that attaches them.
module pfld_checker
    import pfld_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [2:0]         i_mode,
    input logic signed [15:0] i_x_pos,
    input logic signed [15:0] i_y_pos,
    input logic signed [15:0] i_run_length,
    input logic [1:0]         i_color,
    input logic [9:0]         i_byte_index,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [7:0]         o_read_data
);

    // The buffer sweep after reset keeps the input side stalled.
    a_wipe_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled during the clearing sweep");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word shown right after reset");

    // An accepted word keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word accepted back to back");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_data))
        else $error("stalled result word changed");

endmodule

bind page_framebuffer_line_drawer_core pfld_checker u_pfld_checker (.*);

>>> bench/page_framebuffer_line_drawer_core_test.sv
// Self-checking testbench for the page-packed frame buffer pixel and line drawer.
module page_framebuffer_line_drawer_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pfld_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RANDOM_WORDS = 340;
    localparam int REPORT_CAP   = 100;
    localparam logic [1:0] COLOR_NONE = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] len;
        logic [1:0]  color;
        logic [9:0]  index;
    } t_draw_word;

    logic               i_clk;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_mode       = '0;
    logic signed [15:0] i_x_pos      = '0;
    logic signed [15:0] i_y_pos      = '0;
    logic signed [15:0] i_run_length = '0;
    logic [1:0]         i_color      = '0;
    logic [9:0]         i_byte_index = '0;
    logic               o_out_valid;
    logic               i_out_stall  = 1'b0;
    logic [7:0]         o_read_data;

    logic [7:0] frame_shadow [FRAME_SIZE];
    logic [7:0] pending_read_data [$];
    logic [7:0] wanted_byte;
    int         touched_bytes [$];
    int         n_mismatch = 0;
    int         n_checked  = 0;
    int         cycles     = 0;
    int         mode_count [8];
    bit         calm       = 1'b0;

    page_framebuffer_line_drawer_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_x_pos      (i_x_pos),
        .i_y_pos      (i_y_pos),
        .i_run_length (i_run_length),
        .i_color      (i_color),
        .i_byte_index (i_byte_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void paint_byte(int idx, logic [7:0] mask, logic [1:0] color);
        if (idx < 0 || idx >= FRAME_SIZE) return;
        case (color)
            COLOR_BLACK:  frame_shadow[idx] = frame_shadow[idx] & ~mask;
            COLOR_WHITE:  frame_shadow[idx] = frame_shadow[idx] | mask;
            COLOR_INVERT: frame_shadow[idx] = frame_shadow[idx] ^ mask;
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] draw_and_read(t_draw_word w);
        int x, y, len, first, last, lo, hi;
        logic [7:0] rd;
        x   = int'($signed(w.x));
        y   = int'($signed(w.y));
        len = int'($signed(w.len));
        rd  = '0;
        case (w.mode)
            MODE_PIXEL: begin
                if (x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT)
                    paint_byte((y / 8) * SCREEN_WIDTH + x, 8'(1 << (y % 8)), w.color);
            end
            MODE_HRUN: begin
                if (y >= 0 && y < SCREEN_HEIGHT) begin
                    first = (x < 0) ? 0 : x;
                    last  = (x + len > SCREEN_WIDTH) ? SCREEN_WIDTH : x + len;
                    for (int c = first; c < last; c++)
                        paint_byte((y / 8) * SCREEN_WIDTH + c, 8'(1 << (y % 8)), w.color);
                end
            end
            MODE_VRUN: begin
                if (x >= 0 && x < SCREEN_WIDTH) begin
                    first = (y < 0) ? 0 : y;
                    last  = (y + len > SCREEN_HEIGHT) ? SCREEN_HEIGHT : y + len;
                    if (last > first) begin
                        for (int pg = first / 8; pg <= (last - 1) / 8; pg++) begin
                            lo = (pg * 8 < first) ? first - pg * 8 : 0;
                            hi = (pg * 8 + 8 > last) ? last - pg * 8 : 8;
                            paint_byte(pg * SCREEN_WIDTH + x,
                                       8'((1 << hi) - 1) & ~8'((1 << lo) - 1), w.color);
                        end
                    end
                end
            end
            MODE_CLEAR: begin
                foreach (frame_shadow[i]) frame_shadow[i] = '0;
            end
            MODE_READ: begin
                if (int'(w.index) < FRAME_SIZE) rd = frame_shadow[w.index];
            end
            default: ;
        endcase
        return rd;
    endfunction

    function automatic t_draw_word make_word(logic [2:0] mode, int x, int y, int len,
                                             logic [1:0] color, int index);
        t_draw_word w;
        w.mode  = mode;
        w.x     = 16'(x);
        w.y     = 16'(y);
        w.len   = 16'(len);
        w.color = color;
        w.index = 10'(index);
        return w;
    endfunction

    task automatic report_mismatch(string what);
        n_mismatch++;
        if (n_mismatch <= REPORT_CAP) $display("%0t ERROR: %s", $realtime, what);
    endtask

    task automatic send_word(t_draw_word w);
        if (!calm && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= w.mode;
        i_x_pos      <= w.x;
        i_y_pos      <= w.y;
        i_run_length <= w.len;
        i_color      <= w.color;
        i_byte_index <= w.index;
        do @(posedge i_clk); while (o_in_stall);
        pending_read_data.push_back(draw_and_read(w));
        mode_count[w.mode]++;
    endtask

    task automatic read_byte(int idx);
        send_word(make_word(MODE_READ, 0, 0, 0, COLOR_BLACK, idx));
    endtask

    task automatic test_pixels();
        send_word(make_word(MODE_PIXEL, 0, 0, 0, COLOR_WHITE, 0));
        send_word(make_word(MODE_PIXEL, 127, 63, 0, COLOR_WHITE, 0));
        read_byte(0);
        read_byte(FRAME_SIZE - 1);
        send_word(make_word(MODE_PIXEL, 127, 63, 0, COLOR_INVERT, 0));
        send_word(make_word(MODE_PIXEL, -1, 0, 0, COLOR_WHITE, 0));
        send_word(make_word(MODE_PIXEL, 128, 5, 0, COLOR_WHITE, 0));
        send_word(make_word(MODE_PIXEL, 0, 64, 0, COLOR_WHITE, 0));
        send_word(make_word(MODE_PIXEL, -32768, 32767, 0, COLOR_WHITE, 0));
        read_byte(FRAME_SIZE - 1);
    endtask

    task automatic test_hruns();
        send_word(make_word(MODE_HRUN, -5, 7, 200, COLOR_WHITE, 0));
        send_word(make_word(MODE_HRUN, 32767, 3, 32767, COLOR_WHITE, 0));
        send_word(make_word(MODE_HRUN, -32768, 2, 32767, COLOR_WHITE, 0));
        send_word(make_word(MODE_HRUN, 10, 20, 0, COLOR_WHITE, 0));
        send_word(make_word(MODE_HRUN, 10, 20, -3, COLOR_WHITE, 0));
        send_word(make_word(MODE_HRUN, 0, 5, 128, COLOR_NONE, 0));
        send_word(make_word(MODE_HRUN, 120, 7, 8, COLOR_BLACK, 0));
        read_byte(64);
        read_byte(125);
    endtask

    task automatic test_vruns();
        send_word(make_word(MODE_VRUN, 3, 2, 60, COLOR_WHITE, 0));
        send_word(make_word(MODE_VRUN, 3, -10, 100, COLOR_INVERT, 0));
        send_word(make_word(MODE_VRUN, 5, 9, 3, COLOR_WHITE, 0));
        send_word(make_word(MODE_VRUN, 6, 0, 64, COLOR_NONE, 0));
        send_word(make_word(MODE_VRUN, 128, 0, 64, COLOR_WHITE, 0));
        send_word(make_word(MODE_VRUN, 7, 32767, 32767, COLOR_WHITE, 0));
        read_byte(3);
        read_byte(3 + 4 * SCREEN_WIDTH);
        read_byte(5 + SCREEN_WIDTH);
    endtask

    task automatic test_clear_and_spare_modes();
        for (int m = MODE_READ + 1; m < 8; m++)
            send_word(make_word(3'(m), -1, -1, -1, COLOR_NONE, FRAME_SIZE - 1));
        send_word(make_word(MODE_CLEAR, 0, 0, 0, COLOR_BLACK, 0));
        read_byte(3);
    endtask

    task automatic test_random_drawing();
        int effective, pick, x, y, len;
        logic [2:0] mode;
        logic [1:0] color;
        int index;
        effective = 0;
        while (effective < RANDOM_WORDS) begin
            calm = (effective >= 150 && effective < 250);
            pick = $urandom_range(99);
            if (pick < 30)      mode = MODE_READ;
            else if (pick < 48) mode = MODE_PIXEL;
            else if (pick < 70) mode = MODE_HRUN;
            else if (pick < 93) mode = MODE_VRUN;
            else if (pick < 95) mode = MODE_CLEAR;
            else                mode = 3'($urandom_range(7, MODE_READ + 1));
            if ($urandom_range(99) < 12) begin
                x   = int'($signed(16'($urandom)));
                y   = int'($signed(16'($urandom)));
                len = int'($signed(16'($urandom)));
            end else begin
                x   = int'($urandom_range(SCREEN_WIDTH + 31)) - 16;
                y   = int'($urandom_range(SCREEN_HEIGHT + 19)) - 10;
                len = int'($urandom_range(mode == MODE_HRUN ? 150 : 75)) - 4;
            end
            pick = $urandom_range(99);
            if (pick < 5)       color = COLOR_NONE;
            else if (pick < 45) color = COLOR_WHITE;
            else if (pick < 70) color = COLOR_BLACK;
            else                color = COLOR_INVERT;
            if (touched_bytes.size() > 0 && $urandom_range(1))
                index = touched_bytes[$urandom_range(touched_bytes.size() - 1)];
            else
                index = $urandom_range(1023);
            if (mode == MODE_PIXEL || mode == MODE_HRUN || mode == MODE_VRUN) begin
                touched_bytes.push_back(
                    ((y < 0 ? 0 : y >= SCREEN_HEIGHT ? SCREEN_HEIGHT - 1 : y) / 8) * SCREEN_WIDTH
                    + (x < 0 ? 0 : x >= SCREEN_WIDTH ? SCREEN_WIDTH - 1 : x));
                if (touched_bytes.size() > 16) void'(touched_bytes.pop_front());
            end
            send_word(make_word(mode, x, y, len, color, index));
            if (mode <= MODE_READ && (color != COLOR_NONE || mode >= MODE_CLEAR)) effective++;
        end
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 7);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_read_data.size() == 0) begin
                report_mismatch($sformatf("result word %02h with nothing expected", o_read_data));
            end else begin
                wanted_byte = pending_read_data.pop_front();
                n_checked++;
                if (o_read_data !== wanted_byte)
                    report_mismatch($sformatf("read_data %02h, expected %02h",
                                              o_read_data, wanted_byte));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d words outstanding.",
                     cycles, pending_read_data.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        foreach (frame_shadow[i]) frame_shadow[i] = '0;
        foreach (mode_count[i]) mode_count[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_pixels();
        test_hruns();
        test_vruns();
        test_clear_and_spare_modes();
        test_random_drawing();
        i_in_valid <= 1'b0;
        wait (pending_read_data.size() == 0);
        repeat (40) @(posedge i_clk);
        if (pending_read_data.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", pending_read_data.size()));
        $display("Covered %0d pixels, %0d horizontal runs, %0d vertical runs, %0d clears,",
                 mode_count[MODE_PIXEL], mode_count[MODE_HRUN], mode_count[MODE_VRUN],
                 mode_count[MODE_CLEAR]);
        $display("%0d byte reads and %0d words in total; %0d mismatches.",
                 mode_count[MODE_READ], n_checked, n_mismatch);
        if (n_mismatch == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
